[rtl/deq_pkg.sv]
`default_nettype none

package deq_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef logic [CMD_W-1:0]           cmd_t;
  typedef logic signed [WORD_W-1:0]   word_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [COUNT_W-1:0]         count_t;

  localparam cmd_t CMD_PUSH_BACK  = 3'd0;
  localparam cmd_t CMD_POP_FRONT  = 3'd1;
  localparam cmd_t CMD_PUSH_FRONT = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_PEEK_FRONT = 3'd4;
  localparam cmd_t CMD_PEEK_BACK  = 3'd5;
  localparam cmd_t CMD_CLEAR      = 3'd6;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

`default_nettype wire

[rtl/deq_if.sv]
`default_nettype none

interface deq_req_if;
  import deq_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  command;
  word_t value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface deq_rsp_if;
  import deq_pkg::*;

  logic    valid;
  logic    ready;
  word_t   read_value;
  status_t status;
  count_t  count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

`default_nettype wire

[rtl/double_ended_queue.sv]
// A result passes the memory read register and then the result register before it
// appears on rsp.
// Throughput: one command per cycle while rsp takes results; the word store is a
// single RAM, one access per command; head pointer and count update as one is taken.
// Reset: head and count go to zero, pipeline empties; store contents are not cleared.
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);
  import deq_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = PTR_W + 1;

  function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
    return r[PTR_W-1:0];
  endfunction

  // word store
  word_t mem [DEPTH];
  word_t rdata;

  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  logic             accept;
  logic             mem_we, mem_re;
  logic [PTR_W-1:0] waddr, raddr;
  status_t          st;

  logic [PTR_W-1:0] tail_pos, back_pos, head_inc, head_dec;
  logic             empty, full;

  // stage 1: memory read in flight
  logic    s1_valid;
  logic    s1_rd;
  status_t s1_status;
  count_t  s1_count;
  logic    s1_move;

  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  // result register
  logic    out_valid;
  word_t   out_value;
  status_t out_status;
  count_t  out_count;

  assign s1_move   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || s1_move;
  assign accept    = req.valid && req.ready;

  assign empty    = (cnt == '0);
  assign full     = (cnt == CNT_W'(DEPTH));
  assign tail_pos = ring_wrap(SUM_W'(head) + SUM_W'(cnt));
  assign back_pos = ring_wrap(SUM_W'(head) + SUM_W'(cnt) - SUM_W'(1));
  assign head_inc = (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
  assign head_dec = (head == '0) ? PTR_W'(DEPTH - 1) : head - PTR_W'(1);

  always_comb begin
    head_next = head;
    cnt_next  = cnt;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    waddr     = tail_pos;
    raddr     = head;
    st        = ST_OK;
    unique case (req.command) inside
      CMD_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          mem_we   = 1'b1;
          waddr    = tail_pos;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          waddr     = head_dec;
          head_next = head_dec;
          cnt_next  = cnt + CNT_W'(1);
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          mem_re = 1'b1;
          raddr  = head;
          if (req.command == CMD_POP_FRONT) begin
            head_next = head_inc;
            cnt_next  = cnt - CNT_W'(1);
          end
        end
      end
      CMD_POP_BACK, CMD_PEEK_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          mem_re = 1'b1;
          raddr  = back_pos;
          if (req.command == CMD_POP_BACK) begin
            cnt_next = cnt - CNT_W'(1);
          end
        end
      end
      CMD_CLEAR: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          cnt_next  = '0;
          head_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_next};

  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      mem[waddr] <= req.value;
    end
    // read data holds while stage 1 is stalled, since no new command is taken
    if (accept && mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      cnt       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        head <= head_next;
        cnt  <= cnt_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd     <= mem_re;
      s1_status <= st;
      s1_count  <= cnt_ext[COUNT_W-1:0];
    end
    if (s1_move && s1_valid) begin
      out_value  <= s1_rd ? rdata : '0;
      out_status <= s1_status;
      out_count  <= s1_count;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;
  assign rsp.count      = out_count;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("held count above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= PTR_W'(DEPTH - 1))
    else $error("head pointer out of range");

  a_full_push_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && full && (req.command == CMD_PUSH_BACK || req.command == CMD_PUSH_FRONT)
    |=> cnt == $past(cnt) && head == $past(head))
    else $error("push on full queue changed state");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> s1_valid && out_valid && !rsp.ready)
    else $error("input stalled without a full pipeline");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("read and write in one command");
`endif

endmodule

`default_nettype wire
